// File: rtl/lga_pkg.sv
package lga_pkg;

  localparam int MAX_PIXELS = 64;
  localparam int IDX_W      = $clog2(MAX_PIXELS);
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);

  localparam int TIME_W     = 32;
  localparam int COLOR_W    = 24;
  localparam int CHAN_W     = 8;
  localparam int IVL_W      = 16;
  localparam int PCNT_W     = 7;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_COLOR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_COLOR       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT     = 2'd3;

  localparam logic [IVL_W-1:0]  RESET_INTERVAL    = 16'd10;
  localparam logic [PCNT_W-1:0] RESET_PIXEL_COUNT = 7'd8;

  localparam logic [CHAN_W-1:0] PHASE_WRAP = 8'd255;

  // controller to datapath
  typedef struct packed {
    logic             store_time;
    logic             issue;
    logic [IDX_W-1:0] index;
    logic             last;
    logic             end_frame;
  } lga_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             due;
    logic [CNT_W-1:0] count;
    logic             adv;
  } lga_status_t;

endpackage

// File: rtl/lga_time_if.sv
interface lga_time_if;
  import lga_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output now_ms, input ready);
  modport sink   (input valid, input now_ms, output ready);
endinterface

// File: rtl/lga_pixel_if.sv
interface lga_pixel_if;
  import lga_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  pixel_index;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic              last_pixel;

  modport source (output valid, output pixel_index, output red, output green,
                  output blue, output last_pixel, input ready);
  modport sink   (input valid, input pixel_index, input red, input green,
                  input blue, input last_pixel, output ready);
endinterface

// File: rtl/lga_cfg_if.sv
interface lga_cfg_if;
  import lga_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/lga_ctrl.sv
module lga_ctrl
  import lga_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  lga_status_t status,
  output lga_cmd_t    cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic             state;
  logic             state_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic             accept;
  logic             is_last;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_last  = (({1'b0, idx} + CNT_W'(1)) == status.count);

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    cmd.store_time = 1'b0;
    cmd.issue      = 1'b0;
    cmd.index      = idx;
    cmd.last       = is_last;
    cmd.end_frame  = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && status.due) begin
          cmd.store_time = 1'b1;
          idx_next       = '0;
          if (status.count == '0) begin
            // empty frame still moves the phase
            cmd.end_frame = 1'b1;
          end else begin
            state_next = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (status.adv) begin
          cmd.issue = 1'b1;
          if (is_last) begin
            cmd.end_frame = 1'b1;
            state_next    = S_IDLE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

// File: rtl/lga_datapath.sv
module lga_datapath
  import lga_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [TIME_W-1:0] now_ms,
  input  lga_cmd_t          cmd,
  output lga_status_t       status,
  lga_cfg_if.sink           cfg,
  lga_pixel_if.source       pix
);

  localparam int PROD_W = 2 * CHAN_W + 2;

  // settings
  logic [COLOR_W-1:0] start_color;
  logic [COLOR_W-1:0] end_color;
  logic [IVL_W-1:0]   update_interval;
  logic [PCNT_W-1:0]  pixel_count;

  // animation state
  logic [TIME_W-1:0]  last_frame_time;
  logic [CHAN_W-1:0]  phase_step;
  logic [CHAN_W-1:0]  phase_next;
  logic               colors_swapped;

  // multiply stage
  logic                     s1_valid;
  logic signed [PROD_W-1:0] s1_prod [3];
  logic [CHAN_W-1:0]        s1_base [3];
  logic [IDX_W-1:0]         s1_idx;
  logic                     s1_last;

  logic [TIME_W-1:0]  elapsed;
  logic [COLOR_W-1:0] from_color;
  logic [COLOR_W-1:0] to_color;
  logic [CHAN_W-1:0]  pos;
  logic [CHAN_W-1:0]  res [3];
  logic               adv;

  function automatic logic signed [PROD_W-1:0] blend_mul(
    input logic [CHAN_W-1:0] a,
    input logic [CHAN_W-1:0] b,
    input logic [CHAN_W-1:0] p
  );
    logic signed [CHAN_W:0] diff;
    logic signed [CHAN_W:0] ps;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    ps   = $signed({1'b0, p});
    return PROD_W'(ps * diff);
  endfunction

  // signed divide by 255 truncating toward zero, then add the base
  function automatic logic [CHAN_W-1:0] blend_add(
    input logic [CHAN_W-1:0]        base,
    input logic signed [PROD_W-1:0] prod
  );
    logic [PROD_W-1:0]   mag;
    logic [2*CHAN_W:0]   sum;
    logic [CHAN_W-1:0]   q;
    mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    sum = {1'b0, mag[2*CHAN_W-1:0]} + {{(CHAN_W+1){1'b0}}, mag[2*CHAN_W-1:CHAN_W]}
          + (2*CHAN_W+1)'(1);
    q   = sum[2*CHAN_W-1:CHAN_W];
    return prod[PROD_W-1] ? (base - q) : (base + q);
  endfunction

  assign cfg.ready = 1'b1;

  assign adv     = !pix.valid || pix.ready;
  assign elapsed = now_ms - last_frame_time;

  assign status.adv   = adv;
  assign status.due   = !(elapsed < {{(TIME_W-IVL_W){1'b0}}, update_interval});
  assign status.count = (pixel_count > PCNT_W'(MAX_PIXELS)) ? CNT_W'(MAX_PIXELS)
                                                           : CNT_W'(pixel_count);

  assign from_color = colors_swapped ? end_color : start_color;
  assign to_color   = colors_swapped ? start_color : end_color;
  assign pos        = CHAN_W'(cmd.index) + phase_step;
  assign phase_next = phase_step + CHAN_W'(1);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      res[c] = blend_add(s1_base[c], s1_prod[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_color     <= '0;
      end_color       <= '0;
      update_interval <= RESET_INTERVAL;
      pixel_count     <= RESET_PIXEL_COUNT;
      last_frame_time <= '0;
      phase_step      <= '0;
      colors_swapped  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_START_COLOR:     start_color     <= cfg.data[COLOR_W-1:0];
          REG_END_COLOR:       end_color       <= cfg.data[COLOR_W-1:0];
          REG_UPDATE_INTERVAL: update_interval <= cfg.data[IVL_W-1:0];
          REG_PIXEL_COUNT:     pixel_count     <= cfg.data[PCNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.store_time) begin
        last_frame_time <= now_ms;
      end
      if (cmd.end_frame) begin
        if (phase_next == PHASE_WRAP) begin
          phase_step     <= '0;
          colors_swapped <= !colors_swapped;
        end else begin
          phase_step <= phase_next;
        end
      end
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      pix.valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= cmd.issue;
      pix.valid <= s1_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        s1_base[c] <= from_color[(2-c)*CHAN_W +: CHAN_W];
        s1_prod[c] <= blend_mul(from_color[(2-c)*CHAN_W +: CHAN_W],
                                to_color[(2-c)*CHAN_W +: CHAN_W], pos);
      end
      s1_idx          <= cmd.index;
      s1_last         <= cmd.last;
      pix.pixel_index <= s1_idx;
      pix.last_pixel  <= s1_last;
      pix.red         <= res[0];
      pix.green       <= res[1];
      pix.blue        <= res[2];
    end
  end

endmodule

// File: rtl/led_gradient_animator_top.sv
// led gradient animator: animated two-colour gradient for a pixel strip
//
// channels
//   cfg       register writes, index 0 start colour, 1 end colour,
//             2 update interval (ms), 3 pixel count; always ready
//   time_in   one request per millisecond tick carrying now_ms
//   pixel_out one request per pixel: index, red, green, blue, last flag
//
// a tick is due when now_ms - last frame time (mod 2^32) reaches the
// interval; a due tick starts a frame of min(pixel count, 64) pixels,
// a tick that is not due gives nothing and changes nothing
//
// timing: the controller issues one pixel a cycle while pixel_out does not stall,
// through a two-stage multiply / divide-by-255 pipeline whose second stage is
// the output register; time_in stays not ready while pixels are being issued,
// so the next tick waits until the whole frame has been issued
//
// a stall on pixel_out freezes the whole pipeline, nothing is lost
// reset restores colours 0, interval 10, 8 pixels, phase 0, no swap
module led_gradient_animator_top
  import lga_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  lga_cfg_if.sink     cfg,
  lga_time_if.sink    time_in,
  lga_pixel_if.source pixel_out
);

  lga_cmd_t    cmd;
  lga_status_t status;
  logic        in_ready;

  // frame sequencer
  lga_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (time_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign time_in.ready = in_ready;

  // settings, animation state and colour pipeline
  lga_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .now_ms (time_in.now_ms),
    .cmd    (cmd),
    .status (status),
    .cfg    (cfg),
    .pix    (pixel_out)
  );

endmodule
